>>> src/ptb_pkg.sv
`default_nettype none
package ptb_pkg;

  localparam int unsigned IdxBits   = 9;
  localparam logic [63:0] AddrMask  = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] BitPresent  = 64'h1;
  localparam logic [63:0] BitWritable = 64'h2;

  typedef enum logic {
    FuncMap   = 1'b0,
    FuncAlias = 1'b1
  } func_e;

  typedef struct packed {
    logic        func;
    logic [35:0] linear_page;
    logic [35:0] source_page;
    logic [51:0] frame_addr;
    logic [63:0] entry_flags;
    logic [1:0]  keep;
  } req_t;

  typedef struct packed {
    logic        mapped;
    logic        advance;
    logic        status;
    logic [1:0]  tables_created;
    logic [63:0] entry_value;
  } rsp_t;

  typedef enum logic [3:0] {
    StReset,
    StIdle,
    StRead,
    StWait,
    StDecide,
    StClear,
    StLink,
    StFinal,
    StDone
  } state_e;

endpackage
`default_nettype wire

>>> src/page_table_builder_core.sv
`default_nettype none
// Page table builder. An item is taken when start is high and busy is low;
// its single result word appears on rsp_o with done_o high for one cycle and
// cannot be stalled. The tables live in one memory of TABLE_COUNT*512 entries
// with one read and one write port; each level of a walk steps through address,
// memory read and decode. An alias item first walks its source page, without
// creating tables, until that walk misses or ends, and then walks its linear
// page. Each newly allocated table has its 512 entries cleared and is then
// linked. An item that runs out of tables ends with its result in the cycle
// after the decode of the level that needed one. After reset the root table is
// cleared while busy is high.
module page_table_builder_core #(
  parameter int unsigned TABLE_COUNT = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire ptb_pkg::req_t   req_i,
  output logic                 done_o,
  output ptb_pkg::rsp_t        rsp_o,
  input  wire logic            cfg_we_i,
  input  wire logic [39:0]     cfg_wdata_i
);

  localparam int unsigned TW    = $clog2(TABLE_COUNT);
  localparam int unsigned AddrW = TW + ptb_pkg::IdxBits;
  localparam int unsigned CntW  = $clog2(TABLE_COUNT + 1);

  ptb_pkg::state_e state_q, state_d;
  ptb_pkg::req_t   req_q;
  logic [39:0]     base_q;
  logic [CntW-1:0] nft_q, nft_d;
  logic [8:0]      clr_q, clr_d;
  logic [1:0]      lvl_q, lvl_d;
  logic            src_q, src_d;       // walking source (no create)
  logic            srcok_q, srcok_d;
  logic [63:0]     srcval_q, srcval_d;
  logic [AddrW-1:0] srcaddr_q, srcaddr_d;
  logic [TW-1:0]   tab_q, tab_d;
  logic [TW-1:0]   newt_q, newt_d;
  logic [1:0]      made_q, made_d;
  logic            done_q, done_d;
  ptb_pkg::rsp_t   rsp_q, rsp_d;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [63:0]      wdata, rdata;

  ptb_store #(.AddrW(AddrW)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [35:0] page;
  logic [8:0]  slot;
  logic [39:0] pg, idx;
  logic        hit;
  logic [39:0] linkpg;

  always_comb begin
    page = src_q ? req_q.source_page : req_q.linear_page;
    unique case (lvl_q)
      2'd0:    slot = page[35:27];
      2'd1:    slot = page[26:18];
      2'd2:    slot = page[17:9];
      default: slot = page[8:0];
    endcase
    pg  = rdata[51:12];
    idx = pg - base_q;
    hit = (pg != '0) && (idx < 40'(nft_q));
    linkpg = base_q + 40'(newt_q);
  end

  always_comb begin
    state_d = state_q; nft_d = nft_q; clr_d = clr_q; lvl_d = lvl_q;
    src_d = src_q; srcok_d = srcok_q; srcval_d = srcval_q; tab_d = tab_q;
    srcaddr_d = srcaddr_q;
    newt_d = newt_q; made_d = made_q; done_d = 1'b0; rsp_d = rsp_q;
    we = 1'b0; waddr = {tab_q, slot}; wdata = '0; raddr = {tab_q, slot};
    busy = (state_q != ptb_pkg::StIdle);
    unique case (state_q)
      ptb_pkg::StReset: begin
        we = 1'b1; waddr = {TW'(0), clr_q};
        clr_d = clr_q + 9'd1;
        if (clr_q == 9'h1FF) state_d = ptb_pkg::StIdle;
      end
      ptb_pkg::StIdle: begin
        if (start) begin
          lvl_d = '0; tab_d = '0; made_d = '0; srcok_d = 1'b0;
          src_d = (req_i.func == ptb_pkg::FuncAlias);
          state_d = ptb_pkg::StRead;
        end
      end
      ptb_pkg::StRead: state_d = ptb_pkg::StWait;
      ptb_pkg::StWait: state_d = ptb_pkg::StDecide;
      ptb_pkg::StDecide: begin
        if (lvl_q == 2'd3) begin
          if (src_q) begin
            srcok_d = 1'b1; srcval_d = rdata; srcaddr_d = {tab_q, slot};
            src_d = 1'b0; lvl_d = '0; tab_d = '0; state_d = ptb_pkg::StRead;
          end else begin
            state_d = ptb_pkg::StFinal;
          end
        end else if (hit) begin
          tab_d = idx[TW-1:0]; lvl_d = lvl_q + 2'd1; state_d = ptb_pkg::StRead;
        end else if (src_q) begin
          src_d = 1'b0; lvl_d = '0; tab_d = '0; state_d = ptb_pkg::StRead;
        end else if (32'(nft_q) >= TABLE_COUNT) begin
          rsp_d = '{mapped: 1'b0, advance: 1'b0, status: 1'b1,
                    tables_created: made_q, entry_value: '0};
          done_d = 1'b1; state_d = ptb_pkg::StIdle;
        end else begin
          newt_d = nft_q[TW-1:0]; nft_d = nft_q + CntW'(1);
          made_d = made_q + 2'd1; clr_d = '0; state_d = ptb_pkg::StClear;
        end
      end
      ptb_pkg::StClear: begin
        we = 1'b1; waddr = {newt_q, clr_q};
        clr_d = clr_q + 9'd1;
        if (clr_q == 9'h1FF) state_d = ptb_pkg::StLink;
      end
      ptb_pkg::StLink: begin
        we = 1'b1;
        wdata = {12'd0, linkpg, 12'd0} | ptb_pkg::BitPresent | ptb_pkg::BitWritable;
        // a link may land on the source entry when table levels got mixed
        if (srcok_q && waddr == srcaddr_q) srcval_d = wdata;
        tab_d = newt_q; lvl_d = lvl_q + 2'd1; state_d = ptb_pkg::StRead;
      end
      ptb_pkg::StFinal: begin
        rsp_d.status = 1'b0; rsp_d.tables_created = made_q;
        if (req_q.func == ptb_pkg::FuncAlias) begin
          wdata = srcok_q ? ((srcval_q & ptb_pkg::AddrMask) | req_q.entry_flags)
                : (req_q.entry_flags & ~(ptb_pkg::BitPresent | ptb_pkg::AddrMask));
          we = 1'b1; rsp_d.mapped = 1'b1; rsp_d.advance = 1'b1;
          rsp_d.entry_value = wdata;
        end else if (req_q.keep != 2'd0 && (rdata & ptb_pkg::AddrMask) != '0) begin
          rsp_d.mapped = 1'b0; rsp_d.advance = req_q.keep[1];
          rsp_d.entry_value = rdata;
        end else begin
          wdata = {12'd0, req_q.frame_addr} | req_q.entry_flags;
          we = 1'b1; rsp_d.mapped = 1'b1; rsp_d.advance = 1'b1;
          rsp_d.entry_value = wdata;
        end
        state_d = ptb_pkg::StDone;
      end
      ptb_pkg::StDone: begin
        done_d = 1'b1; state_d = ptb_pkg::StIdle;
      end
      default: state_d = ptb_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptb_pkg::StReset; nft_q <= CntW'(1); clr_q <= '0; lvl_q <= '0;
      src_q <= 1'b0; srcok_q <= 1'b0; tab_q <= '0; newt_q <= '0; made_q <= '0;
      done_q <= 1'b0; base_q <= 40'd16;
    end else begin
      state_q <= state_d; nft_q <= nft_d; clr_q <= clr_d; lvl_q <= lvl_d;
      src_q <= src_d; srcok_q <= srcok_d; tab_q <= tab_d; newt_q <= newt_d;
      made_q <= made_d; done_q <= done_d;
      if (cfg_we_i) base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ptb_pkg::StIdle && start) req_q <= req_i;
    srcval_q  <= srcval_d;
    srcaddr_q <= srcaddr_d;
    rsp_q     <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_nft_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(nft_q) <= TABLE_COUNT) else $error("free table count overran");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ptb_pkg::StIdle) else $error("result while busy");
  a_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ptb_pkg::StLink |-> $past(state_q) == ptb_pkg::StClear)
    else $error("link without clear");

endmodule
`default_nettype wire

>>> src/ptb_store.sv
`default_nettype none
module ptb_store #(
  parameter int unsigned AddrW = 13
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [63:0]      wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [63:0]      rdata_o
);

  logic [63:0] mem [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> tb/sv/page_table_builder_core_tb.sv
`default_nettype none
module page_table_builder_core_tb;

  localparam int unsigned TABLE_COUNT = 16;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [39:0] BASE_RESET = 40'd16;
  localparam logic [39:0] BASE_MAX = 40'hFF_FFFF_FFFF;

  typedef enum int {WalkFound, WalkMissing, WalkFull} walk_e;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  ptb_pkg::req_t  req;
  logic           done;
  ptb_pkg::rsp_t  rsp;
  logic           cfg_we;
  logic [39:0]    cfg_wdata;

  page_table_builder_core #(.TABLE_COUNT(TABLE_COUNT)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .done_o     (done),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // shadow of the table memory and allocator
  logic [63:0] shadow_tables[TABLE_COUNT*512];
  int unsigned next_table;
  logic [39:0] root_page;

  ptb_pkg::rsp_t pending_rsp_q[$];
  int unsigned errors;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned exhausted_seen;
  int unsigned idle_pct;
  int unsigned quiet_cycles;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int unsigned link_target(logic [63:0] e);
    logic [39:0] pg;
    logic [39:0] idx;
    pg = e[51:12];
    if (pg == '0) return TABLE_COUNT;
    idx = pg - root_page;
    if (idx >= next_table) return TABLE_COUNT;
    return int'(idx);
  endfunction

  function automatic walk_e walk_page(logic [35:0] pg, bit create,
                                      output int unsigned slot,
                                      inout int unsigned made);
    int unsigned t;
    int unsigned nxt;
    int unsigned pos;
    logic [39:0] tpage;
    t = 0;
    slot = 0;
    for (int lvl = 0; lvl < 3; lvl++) begin
      pos = t * 512 + 32'(pg[35-9*lvl -: 9]);
      nxt = link_target(shadow_tables[pos]);
      if (nxt >= TABLE_COUNT) begin
        if (!create) return WalkMissing;
        if (next_table >= TABLE_COUNT) return WalkFull;
        nxt = next_table++;
        for (int k = 0; k < 512; k++) shadow_tables[nxt*512+k] = '0;
        tpage = root_page + 40'(nxt);
        shadow_tables[pos] = {12'b0, tpage, 12'b0} | ptb_pkg::BitPresent
                             | ptb_pkg::BitWritable;
        made++;
      end
      t = nxt;
    end
    slot = t * 512 + 32'(pg[8:0]);
    return WalkFound;
  endfunction

  function automatic ptb_pkg::rsp_t build_entry(ptb_pkg::req_t w);
    ptb_pkg::rsp_t r;
    int unsigned made;
    int unsigned dst;
    int unsigned src;
    walk_e       wd;
    walk_e       ws;
    logic [63:0] cur;
    r = '0;
    made = 0;
    if (w.func == ptb_pkg::FuncMap) begin
      wd = walk_page(w.linear_page, 1'b1, dst, made);
      if (wd == WalkFull) begin
        r.status = 1'b1;
      end else begin
        cur = shadow_tables[dst];
        if (w.keep != 2'd0 && (cur & ptb_pkg::AddrMask) != '0) begin
          r.entry_value = cur;
        end else begin
          r.entry_value = {12'b0, w.frame_addr} | w.entry_flags;
          shadow_tables[dst] = r.entry_value;
          r.mapped = 1'b1;
        end
        r.advance = r.mapped || w.keep >= 2'd2;
      end
    end else begin
      ws = walk_page(w.source_page, 1'b0, src, made);
      wd = walk_page(w.linear_page, 1'b1, dst, made);
      if (wd == WalkFull) begin
        r.status = 1'b1;
      end else begin
        if (ws == WalkFound)
          r.entry_value = (shadow_tables[src] & ptb_pkg::AddrMask) | w.entry_flags;
        else
          r.entry_value = w.entry_flags & ~(ptb_pkg::BitPresent | ptb_pkg::AddrMask);
        shadow_tables[dst] = r.entry_value;
        r.mapped = 1'b1;
        r.advance = 1'b1;
      end
    end
    r.tables_created = made[1:0];
    return r;
  endfunction

  function automatic ptb_pkg::req_t page_op(ptb_pkg::func_e f, logic [35:0] lin,
                                            logic [35:0] src, logic [51:0] pa,
                                            logic [63:0] fl, logic [1:0] kp);
    ptb_pkg::req_t w;
    w.func = f;
    w.linear_page = lin;
    w.source_page = src;
    w.frame_addr = pa;
    w.entry_flags = fl;
    w.keep = kp;
    return w;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH word %0d %s: got %h want %h", words_checked, field, got, want);
    errors++;
  endtask

  // one word per result strobe, checked against the oldest prediction
  always @(posedge clk_i) begin
    ptb_pkg::rsp_t want;
    if (rst_ni && done) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected result", rsp.entry_value, 64'd0);
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp.mapped !== want.mapped)
          report_mismatch("mapped", 64'(rsp.mapped), 64'(want.mapped));
        if (rsp.advance !== want.advance)
          report_mismatch("advance", 64'(rsp.advance), 64'(want.advance));
        if (rsp.status !== want.status)
          report_mismatch("status", 64'(rsp.status), 64'(want.status));
        if (rsp.tables_created !== want.tables_created)
          report_mismatch("tables_created", 64'(rsp.tables_created),
                          64'(want.tables_created));
        if (rsp.entry_value !== want.entry_value)
          report_mismatch("entry_value", rsp.entry_value, want.entry_value);
      end
      words_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress, %0d results outstanding", pending_rsp_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // start stays high across back-to-back words; it drops only for a gap or a drain
  task automatic send_word(ptb_pkg::req_t w);
    ptb_pkg::rsp_t want;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    req <= w;
    do @(posedge clk_i); while (busy);
    want = build_entry(w);
    if (want.status) exhausted_seen++;
    pending_rsp_q.push_back(want);
    words_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_root_page(logic [39:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    root_page = v;
    cfg_we <= 1'b0;
  endtask

  // root at the top page: link pages wrap past 2^40
  task automatic test_base_wrap();
    write_root_page(BASE_MAX);
    send_word(page_op(ptb_pkg::FuncMap, 36'd0, 36'd0, 52'h1000, 64'h3, 2'd0));
    send_word(page_op(ptb_pkg::FuncMap, '1, '1, '1, '1, 2'd0));
    send_word(page_op(ptb_pkg::FuncMap, 36'd7, 36'd0, 52'd0, 64'd0, 2'd0));
  endtask

  task automatic test_keep_modes();
    send_word(page_op(ptb_pkg::FuncMap, 36'd0, 36'd0, 52'h2000, 64'h7, 2'd1));
    send_word(page_op(ptb_pkg::FuncMap, 36'd0, 36'd0, 52'h3000, 64'h7, 2'd2));
    send_word(page_op(ptb_pkg::FuncMap, 36'd0, 36'd0, 52'h4000, 64'h7, 2'd3));
    send_word(page_op(ptb_pkg::FuncMap, 36'd0, 36'd0, 52'h5000, 64'h7, 2'd0));
    // entry holds flags only, so keep does not protect it
    send_word(page_op(ptb_pkg::FuncMap, 36'd7, 36'd0, 52'h6000, 64'h1, 2'd1));
  endtask

  task automatic test_alias();
    send_word(page_op(ptb_pkg::FuncAlias, 36'd9, 36'd0, '1, '1, 2'd3));
    send_word(page_op(ptb_pkg::FuncAlias, 36'd10, 36'h1_2345_6789, 52'd0, '1, 2'd0));
    send_word(page_op(ptb_pkg::FuncAlias, 36'd0, 36'd0, 52'd0,
                      64'h8000_0000_0000_0002, 2'd1));
    send_word(page_op(ptb_pkg::FuncAlias, 36'd11, 36'd8, 52'd0, 64'h0, 2'd0));
  endtask

  // old links are read again against the new root page
  task automatic test_stale_links();
    write_root_page(40'd1);
    send_word(page_op(ptb_pkg::FuncMap, 36'd0, 36'd0, 52'h7000, 64'h3, 2'd1));
    send_word(page_op(ptb_pkg::FuncAlias, 36'd1, 36'd0, 52'd0, 64'h3, 2'd0));
  endtask

  task automatic test_exhaustion();
    write_root_page(BASE_RESET);
    send_word(page_op(ptb_pkg::FuncMap, 36'd0, 36'd0, 52'h8000, 64'h3, 2'd0));
    send_word(page_op(ptb_pkg::FuncMap, {9'd0, 9'd1, 9'd0, 9'd5}, 36'd0, 52'h9000,
                      64'h3, 2'd0));
    send_word(page_op(ptb_pkg::FuncMap, {9'd0, 9'd2, 9'd0, 9'd5}, 36'd0, 52'hA000,
                      64'h3, 2'd0));
    send_word(page_op(ptb_pkg::FuncAlias, {9'd3, 27'd0}, 36'd0, 52'd0, 64'h3, 2'd0));
    send_word(page_op(ptb_pkg::FuncMap, 36'd5, 36'd0, 52'hB000, 64'h3, 2'd2));
  endtask

  function automatic logic [35:0] pick_page();
    if ($urandom_range(99) < 80) return {27'd0, 9'($urandom)};
    return {4'($urandom), 32'($urandom)};
  endfunction

  task automatic test_random(int unsigned count);
    ptb_pkg::req_t w;
    int unsigned pcts[4] = '{0, 57, 0, 21};
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = pcts[ph];
      for (int unsigned i = 0; i < count / 4; i++) begin
        w.func = ($urandom_range(3) == 0) ? ptb_pkg::FuncAlias : ptb_pkg::FuncMap;
        w.linear_page = pick_page();
        w.source_page = pick_page();
        w.frame_addr = {20'($urandom), 32'($urandom)};
        w.entry_flags = {$urandom, $urandom};
        w.keep = 2'($urandom);
        send_word(w);
        if (i % 100 == 99) drain();
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    exhausted_seen = 0;
    idle_pct = 0;
    quiet_cycles = 0;
    for (int k = 0; k < TABLE_COUNT * 512; k++) shadow_tables[k] = '0;
    next_table = 1;
    root_page = BASE_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_base_wrap();
    test_keep_modes();
    test_alias();
    test_stale_links();
    test_exhaustion();
    test_random(1950);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_rsp_q.size() != 0) begin
      report_mismatch("results never arrived", 64'(pending_rsp_q.size()), 64'd0);
    end
    $display("Covered %0d words (%0d hit table exhaustion) over root pages max, 1, 16,",
             words_sent, exhausted_seen);
    $display("with maps, aliases, all keep modes and sender gaps; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
src/ptb_pkg.sv
src/ptb_store.sv
src/page_table_builder_core.sv
tb/sv/page_table_builder_core_tb.sv
